// ===== design/sudisp_pkg.sv =====
// shared constants for the shuffled unique id dispenser
`timescale 1ns / 1ps
package sudisp_pkg;

	localparam int DEFAULT_POOL_DEPTH = 1024;
	localparam int ID_W = 16;
	localparam int RAND_W = 32;

	localparam logic [1:0] CMD_INIT = 2'd0;
	localparam logic [1:0] CMD_SHUFFLE = 2'd1;
	localparam logic [1:0] CMD_GET = 2'd2;
	localparam logic [1:0] CMD_RELEASE = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NOT_INIT = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_IGNORED = 3'd3;
	localparam logic [2:0] ST_BAD_RANGE = 3'd4;

	localparam logic ADDR_FIRST_ID = 1'b0;
	localparam logic ADDR_LAST_ID = 1'b1;

endpackage

// ===== design/shuffled_unique_id_dispenser.sv =====
// top level: pool store, fill walker, restoring divider and swap sequencer
// init: writes each id of the range into the store; shuffle step: modulo, then read j, read pos, write j, write pos
// get next: store read in S_GET, id out in S_GET_OUT; release and every refused request: result straight from idle
// the 32-bit modulo runs one quotient bit a cycle on one subtract/compare unit
// one request at a time, busy is high while one is in progress
// arst_n clears all flags and counters; the store content is not cleared
`timescale 1ns / 1ps
module shuffled_unique_id_dispenser #(
	parameter int POOL_DEPTH = sudisp_pkg::DEFAULT_POOL_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic [sudisp_pkg::RAND_W-1:0] random_word,
	output logic                          done,
	output logic [sudisp_pkg::ID_W-1:0]   id_value,
	output logic [2:0]                    status,
	output logic                          shuffle_done,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CW = $clog2(POOL_DEPTH + 1);
	localparam int RW = CW + 1;
	localparam int IW = sudisp_pkg::ID_W;
	localparam int DW = sudisp_pkg::RAND_W;
	localparam int DCW = $clog2(DW);
	localparam logic [IW:0] DEPTH_N = (IW + 1)'(POOL_DEPTH);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_FILL = 4'd1;
	localparam logic [3:0] S_DIV = 4'd2;
	localparam logic [3:0] S_RD_J = 4'd3;
	localparam logic [3:0] S_RD_P = 4'd4;
	localparam logic [3:0] S_WR_J = 4'd5;
	localparam logic [3:0] S_WR_P = 4'd6;
	localparam logic [3:0] S_GET = 4'd7;
	localparam logic [3:0] S_GET_OUT = 4'd8;

	logic [3:0]    state_q;
	logic [IW-1:0] first_q, last_q;
	logic [CW-1:0] count_q, next_q;
	logic [AW-1:0] pos_q, fill_q, j_q;
	logic          shuffling_q, ready_q;
	logic [DW-1:0] dividend_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] divisor_q;
	logic [DCW-1:0] bit_q;
	logic [IW-1:0] t_q, rd_q;
	logic [IW-1:0] mem [POOL_DEPTH];

	logic          accept, cfg_wr;
	logic [IW:0]   n_ids;
	logic          bad_range;
	logic [RW-1:0] trial, trial_sub;
	logic          trial_ge;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [IW-1:0] wdata;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == sudisp_pkg::ADDR_LAST_ID) ? {16'b0, last_q} : {16'b0, first_q};

	assign n_ids = {1'b0, last_q} - {1'b0, first_q} + (IW + 1)'(1);
	assign bad_range = (last_q < first_q) || (n_ids > DEPTH_N);

	// one restoring step of the modulo
	assign trial = {rem_q[RW-2:0], dividend_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});
	assign trial_sub = trial - {1'b0, divisor_q};

	always_comb begin
		we = 1'b0;
		waddr = fill_q;
		wdata = IW'(first_q + IW'(fill_q));
		raddr = j_q;
		case (state_q)
			S_FILL: begin
				we = 1'b1;
			end
			S_RD_P: begin
				raddr = pos_q;
			end
			S_WR_J: begin
				we = 1'b1;
				waddr = j_q;
				wdata = rd_q;
			end
			S_WR_P: begin
				we = 1'b1;
				waddr = pos_q;
				wdata = t_q;
			end
			S_GET: begin
				raddr = next_q[AW-1:0];
			end
			default: begin
				raddr = j_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '0;
			last_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == sudisp_pkg::ADDR_FIRST_ID) begin
				first_q <= pwdata[IW-1:0];
			end else begin
				last_q <= pwdata[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				dividend_q <= random_word;
				rem_q <= '0;
				divisor_q <= CW'(pos_q) + CW'(1);
			end
			S_DIV: begin
				dividend_q <= {dividend_q[DW-2:0], 1'b0};
				rem_q <= trial_ge ? trial_sub : trial;
			end
			S_RD_P: begin
				t_q <= rd_q;
			end
			default: begin
				t_q <= t_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			next_q <= '0;
			pos_q <= '0;
			fill_q <= '0;
			j_q <= '0;
			bit_q <= '0;
			shuffling_q <= 1'b0;
			ready_q <= 1'b0;
			done <= 1'b0;
			id_value <= '0;
			status <= sudisp_pkg::ST_OK;
			shuffle_done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_value <= '0;
						status <= sudisp_pkg::ST_OK;
						shuffle_done <= ready_q;
						case (cmd)
							sudisp_pkg::CMD_INIT: begin
								if (ready_q) begin
									status <= sudisp_pkg::ST_IGNORED;
									done <= 1'b1;
								end else if (bad_range) begin
									status <= sudisp_pkg::ST_BAD_RANGE;
									done <= 1'b1;
								end else begin
									count_q <= CW'(n_ids);
									pos_q <= AW'(n_ids - (IW + 1)'(1));
									next_q <= '0;
									shuffling_q <= 1'b1;
									fill_q <= '0;
									state_q <= S_FILL;
								end
							end
							sudisp_pkg::CMD_SHUFFLE: begin
								if (!shuffling_q) begin
									status <= sudisp_pkg::ST_IGNORED;
									done <= 1'b1;
								end else begin
									bit_q <= '0;
									state_q <= S_DIV;
								end
							end
							sudisp_pkg::CMD_GET: begin
								if (!ready_q) begin
									status <= sudisp_pkg::ST_NOT_INIT;
									done <= 1'b1;
								end else if (next_q >= count_q) begin
									status <= sudisp_pkg::ST_EXHAUSTED;
									done <= 1'b1;
								end else begin
									state_q <= S_GET;
								end
							end
							default: begin
								if (ready_q || shuffling_q) begin
									count_q <= '0;
									next_q <= '0;
									pos_q <= '0;
									shuffling_q <= 1'b0;
									ready_q <= 1'b0;
									shuffle_done <= 1'b0;
								end else begin
									status <= sudisp_pkg::ST_IGNORED;
								end
								done <= 1'b1;
							end
						endcase
					end
				end
				S_FILL: begin
					fill_q <= fill_q + AW'(1);
					if (fill_q == pos_q) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					bit_q <= bit_q + DCW'(1);
					if (bit_q == DCW'(DW - 1)) begin
						j_q <= trial_ge ? AW'(trial_sub) : AW'(trial);
						state_q <= S_RD_J;
					end
				end
				S_RD_J: begin
					state_q <= S_RD_P;
				end
				S_RD_P: begin
					state_q <= S_WR_J;
				end
				S_WR_J: begin
					state_q <= S_WR_P;
				end
				S_WR_P: begin
					if (pos_q == '0) begin
						shuffling_q <= 1'b0;
						ready_q <= 1'b1;
						shuffle_done <= 1'b1;
					end else begin
						pos_q <= pos_q - AW'(1);
					end
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_GET: begin
					state_q <= S_GET_OUT;
				end
				S_GET_OUT: begin
					id_value <= rd_q;
					next_q <= next_q + CW'(1);
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
